### design/mbe_pkg.sv
// package for the multiset bag engine
// sizes, command and status codes, and the result record; no dependencies
package mbe_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CMD_W       = 2;
  localparam int IN_W        = 32;
  localparam int OUT_W       = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_REMOVE_ALL = 2'd1,
    CMD_REMOVE_ONE = 2'd2,
    CMD_COUNT      = 2'd3
  } cmd_t;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] match_count;
    logic             found;
    logic [OUT_W-1:0] occupancy;
    logic             is_empty;
  } result_t;

endpackage

### design/mbe_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module mbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mbe_scan.sv
// scan engine: walks the stored entries once per command, counts matches,
// compacts the store on removal and appends on insert; uses mbe_pkg, mbe_ram
module mbe_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  mbe_pkg::cmd_t                 cmd,
  input  logic [mbe_pkg::VALUE_WIDTH-1:0] key_in,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mbe_pkg::result_t              res
);
  import mbe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                 state, state_next;
  cmd_t                   op;
  logic [VALUE_WIDTH-1:0] key;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [CNT_W-1:0]       rd_idx, rd_idx_next;
  logic [CNT_W-1:0]       wr_idx, wr_idx_next;
  logic [CNT_W-1:0]       hits, hits_next;
  logic                   pend, pend_next;
  logic                   dropped, dropped_next;

  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;

  logic issue, finish, hit, drop, removing, full, accept;
  logic [CNT_W-1:0] hits_tot;
  logic [CNT_W-1:0] new_cnt;
  logic [CNT_W-1:0] mc;

  mbe_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_idx[ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign removing  = (op == CMD_REMOVE_ALL) || (op == CMD_REMOVE_ONE);
  assign full      = (cnt == CNT_W'(DEPTH));
  assign issue     = (state == ST_SCAN) && (rd_idx < cnt);
  assign finish    = (state == ST_SCAN) && !issue && !pend && res_ready;
  assign hit       = pend && (rdata == key);
  assign drop      = hit && ((op == CMD_REMOVE_ALL) ||
                             ((op == CMD_REMOVE_ONE) && !dropped));
  assign hits_tot  = hits;

  // compaction writes land at or below slots already read
  always_comb begin
    we    = 1'b0;
    waddr = wr_idx[ADDR_W-1:0];
    wdata = rdata;
    if (finish) begin
      waddr = cnt[ADDR_W-1:0];
      wdata = key;
      we    = (op == CMD_INSERT) && !full;
    end else if (pend && !drop && removing) begin
      we = 1'b1;
    end
  end

  always_comb begin
    new_cnt = wr_idx;
    if ((op == CMD_INSERT) && !full) begin
      new_cnt = cnt + CNT_W'(1);
    end
    case (op)
      CMD_INSERT:     mc = full ? '0 : CNT_W'(1);
      CMD_REMOVE_ONE: mc = CNT_W'(hits_tot != '0);
      CMD_REMOVE_ALL: mc = hits_tot;
      CMD_COUNT:      mc = hits_tot;
      default:        mc = '0;
    endcase
    res.status      = ((op == CMD_INSERT) && full) ? STATUS_FULL : STATUS_DONE;
    res.match_count = OUT_W'(mc);
    res.found       = (hits_tot != '0);
    res.occupancy   = OUT_W'(new_cnt);
    res.is_empty    = (new_cnt == '0);
  end

  assign res_valid = finish;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rd_idx_next  = rd_idx;
    wr_idx_next  = wr_idx;
    hits_next    = hits;
    pend_next    = issue;
    dropped_next = dropped;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next   = ST_SCAN;
          rd_idx_next  = '0;
          wr_idx_next  = '0;
          hits_next    = '0;
          dropped_next = 1'b0;
          pend_next    = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_next = rd_idx + CNT_W'(1);
        end
        if (hit) begin
          hits_next = hits + CNT_W'(1);
        end
        if (drop) begin
          dropped_next = 1'b1;
        end
        if (pend && !drop) begin
          wr_idx_next = wr_idx + CNT_W'(1);
        end
        if (finish) begin
          cnt_next   = new_cnt;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= rd_idx_next;
    wr_idx  <= wr_idx_next;
    hits    <= hits_next;
    dropped <= dropped_next;
    if (accept) begin
      op  <= cmd;
      key <= key_in;
    end
  end

endmodule

### design/multiset_bag_engine_top.sv
// multiset bag engine top: transfer handshakes and the result register
// path from input transfer to result valid: the scan engine's pass over the stored entries, then the result register
// a new command is accepted only once the previous scan has finished, and each scan reads one entry
// per cycle from the single store memory
// reset clears the entry count and control; store contents stay undefined
// uses mbe_pkg and mbe_scan
module multiset_bag_engine_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               cmd,
  input  logic [mbe_pkg::IN_W-1:0] item_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     status,
  output logic [mbe_pkg::OUT_W-1:0] match_count,
  output logic                     found,
  output logic [mbe_pkg::OUT_W-1:0] occupancy,
  output logic                     is_empty
);
  import mbe_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t res_q;

  mbe_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(in_valid),
    .cmd_ready(in_ready),
    .cmd      (cmd_t'(cmd)),
    .key_in   (VALUE_WIDTH'(item_value)),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign status      = res_q.status;
  assign match_count = res_q.match_count;
  assign found       = res_q.found;
  assign occupancy   = res_q.occupancy;
  assign is_empty    = res_q.is_empty;

endmodule
